FILE: src/vertex_pick_select_top_assert.svh
// Assertion macros used by the vertex pick and select back end (vps_back).
`ifndef VERTEX_PICK_SELECT_TOP_ASSERT_SVH
`define VERTEX_PICK_SELECT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock, held off during reset.
`define VPS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, held off during reset.
`define VPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/vps_pkg.sv
// Shared types and constants of the vertex pick and select block.
package vps_pkg;

   localparam int COORD_W     = 16;
   localparam int INDEX_W     = 16;
   localparam int TOTAL_W     = INDEX_W + 1;
   localparam int DIST_W      = 34;
   localparam int PROD_W      = 2 * COORD_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [1:0] {
      SEL_ALL,
      SEL_NEAREST,
      SEL_PLANES,
      SEL_NONE
   } sel_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SELECT_MODE,
      CSR_PICK_POINT,
      CSR_PICK_RADIUS,
      CSR_PLANE_FIRST,
      CSR_PLANE_SECOND,
      CSR_PLANE_THIRD,
      CSR_PLANE_FOURTH
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } pick_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] d;
      logic signed [COORD_W-1:0] c;
      logic signed [COORD_W-1:0] b;
      logic signed [COORD_W-1:0] a;
   } plane_type;

   typedef struct packed {
      sel_mode_type           select_mode;
      pick_type               pick;
      logic [DIST_W-1:0]      radius_sq;
      plane_type [3:0]        planes;
   } cfg_type;

   typedef struct packed {
      logic                      mesh_end;
      logic signed [COORD_W-1:0] pos_w;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_x;
   } req_payload_type;

   typedef struct packed {
      logic                      has_point;
      logic [INDEX_W-1:0]        vertex_index;
      logic signed [COORD_W-1:0] sel_x;
      logic signed [COORD_W-1:0] sel_y;
      logic signed [COORD_W-1:0] sel_z;
      logic signed [COORD_W-1:0] sel_w;
      logic [TOTAL_W-1:0]        selected_total;
      logic                      final_result;
   } rsp_payload_type;

   // Vertex with its registered squared differences and plane products.
   typedef struct packed {
      req_payload_type               vtx;
      logic [PROD_W-1:0]             sq_x;
      logic [PROD_W-1:0]             sq_y;
      logic [PROD_W-1:0]             sq_z;
      logic [3:0][2:0][PROD_W-1:0]   plane_prod;
   } prod_type;

endpackage

FILE: src/vps_csr.sv
// Configuration register file of the vertex pick and select block.
module vps_csr
   import vps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SELECT_MODE:  cfg_in.select_mode = sel_mode_type'(csr_wdata[1:0]);
            CSR_PICK_POINT:   cfg_in.pick        = pick_type'(csr_wdata[3*COORD_W-1:0]);
            CSR_PICK_RADIUS:  cfg_in.radius_sq   = csr_wdata[DIST_W-1:0];
            CSR_PLANE_FIRST:  cfg_in.planes[0]   = plane_type'(csr_wdata);
            CSR_PLANE_SECOND: cfg_in.planes[1]   = plane_type'(csr_wdata);
            CSR_PLANE_THIRD:  cfg_in.planes[2]   = plane_type'(csr_wdata);
            CSR_PLANE_FOURTH: cfg_in.planes[3]   = plane_type'(csr_wdata);
            default: ; // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/vps_front.sv
// Input register and product register of the vertex pick and select block.
module vps_front
   import vps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            prod_valid,
   output prod_type        prod,
   input  logic            prod_take
);

   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_ff;
   logic            prod_valid_ff;
   logic            prod_valid_in;
   prod_type        prod_ff;
   prod_type        prod_in;
   logic            accept;
   logic            prod_load;

   assign prod_load = in_valid_ff && (!prod_valid_ff || prod_take);
   assign req_stall = in_valid_ff && !prod_load;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (prod_load) begin
         in_valid_in = 1'b0;
      end
      prod_valid_in = prod_valid_ff;
      if (prod_load) begin
         prod_valid_in = 1'b1;
      end else if (prod_take) begin
         prod_valid_in = 1'b0;
      end
   end

   // Squared distance terms and the twelve plane products, all in parallel.
   always_comb begin
      logic signed [COORD_W:0]       dx;
      logic signed [COORD_W:0]       dy;
      logic signed [COORD_W:0]       dz;
      logic signed [2*COORD_W+1:0]   qx;
      logic signed [2*COORD_W+1:0]   qy;
      logic signed [2*COORD_W+1:0]   qz;
      logic signed [PROD_W-1:0]      pa;
      logic signed [PROD_W-1:0]      pb;
      logic signed [PROD_W-1:0]      pc;
      dx = {in_ff.pos_x[COORD_W-1], in_ff.pos_x} - {cfg.pick.x[COORD_W-1], cfg.pick.x};
      dy = {in_ff.pos_y[COORD_W-1], in_ff.pos_y} - {cfg.pick.y[COORD_W-1], cfg.pick.y};
      dz = {in_ff.pos_z[COORD_W-1], in_ff.pos_z} - {cfg.pick.z[COORD_W-1], cfg.pick.z};
      qx = (2*COORD_W+2)'(dx) * (2*COORD_W+2)'(dx);
      qy = (2*COORD_W+2)'(dy) * (2*COORD_W+2)'(dy);
      qz = (2*COORD_W+2)'(dz) * (2*COORD_W+2)'(dz);
      prod_in      = '0;
      prod_in.vtx  = in_ff;
      prod_in.sq_x = qx[PROD_W-1:0];
      prod_in.sq_y = qy[PROD_W-1:0];
      prod_in.sq_z = qz[PROD_W-1:0];
      for (int i = 0; i < 4; i++) begin
         pa = PROD_W'(cfg.planes[i].a) * PROD_W'(in_ff.pos_x);
         pb = PROD_W'(cfg.planes[i].b) * PROD_W'(in_ff.pos_y);
         pc = PROD_W'(cfg.planes[i].c) * PROD_W'(in_ff.pos_z);
         prod_in.plane_prod[i][0] = pa;
         prod_in.plane_prod[i][1] = pb;
         prod_in.plane_prod[i][2] = pc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_payload;
      end
      if (prod_load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod       = prod_ff;

endmodule

FILE: src/vps_back.sv
// Selection logic, per-mesh state and result register of the block.
`include "vertex_pick_select_top_assert.svh"

module vps_back
   import vps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            prod_valid,
   input  prod_type        prod,
   output logic            prod_take,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam logic [TOTAL_W-1:0] COUNT_MAX = '1;

   logic [INDEX_W-1:0]   vertex_counter_ff;
   logic [INDEX_W-1:0]   vertex_counter_in;
   logic [TOTAL_W-1:0]   selected_count_ff;
   logic [TOTAL_W-1:0]   selected_count_in;
   logic                 best_valid_ff;
   logic                 best_valid_in;
   logic [DIST_W-1:0]    best_dist_ff;
   logic [INDEX_W-1:0]   best_index_ff;
   req_payload_type      best_vtx_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_payload_type      rsp_ff;
   rsp_payload_type      rsp_in;

   logic                 fire;
   logic                 hit;
   logic                 nearer;
   logic                 has_rsp;
   logic                 inside_all;
   logic [DIST_W-1:0]    dist_sq;
   logic [DIST_W-1:0]    limit;
   logic [TOTAL_W-1:0]   count_next;
   logic signed [DIST_W-1:0] plane_sum [4];

   always_comb begin
      dist_sq = {2'b00, prod.sq_x} + {2'b00, prod.sq_y} + {2'b00, prod.sq_z};
      for (int i = 0; i < 4; i++) begin
         plane_sum[i] = {{2{prod.plane_prod[i][0][PROD_W-1]}}, prod.plane_prod[i][0]}
                      + {{2{prod.plane_prod[i][1][PROD_W-1]}}, prod.plane_prod[i][1]}
                      + {{2{prod.plane_prod[i][2][PROD_W-1]}}, prod.plane_prod[i][2]}
                      + {{(DIST_W-COORD_W-8){cfg.planes[i].d[COORD_W-1]}},
                         cfg.planes[i].d, 8'h00};
      end
      inside_all = plane_sum[0][DIST_W-1] && plane_sum[1][DIST_W-1]
                && plane_sum[2][DIST_W-1] && plane_sum[3][DIST_W-1];
      if (best_valid_ff) begin
         limit = best_dist_ff;
      end else if (cfg.radius_sq == '0) begin
         limit = '1;
      end else begin
         limit = cfg.radius_sq;
      end
      nearer = 1'b0;
      hit    = 1'b0;
      case (cfg.select_mode)
         SEL_ALL:     hit    = 1'b1;
         SEL_NEAREST: nearer = dist_sq < limit;
         SEL_PLANES:  hit    = inside_all;
         SEL_NONE:    hit    = 1'b0;
         default:     hit    = 1'b0;
      endcase
      count_next = (hit && selected_count_ff != COUNT_MAX) ? selected_count_ff + 1'b1
                                                            : selected_count_ff;
      has_rsp = hit || prod.vtx.mesh_end;
   end

   // Retire an item when it has no result or the result register frees up.
   assign fire      = prod_valid && (!has_rsp || !rsp_valid_ff || !rsp_stall);
   assign prod_take = fire;

   always_comb begin
      rsp_in              = '0;
      rsp_in.final_result = prod.vtx.mesh_end;
      if (cfg.select_mode == SEL_NEAREST) begin
         if (nearer) begin
            rsp_in.has_point      = 1'b1;
            rsp_in.vertex_index   = vertex_counter_ff;
            rsp_in.sel_x          = prod.vtx.pos_x;
            rsp_in.sel_y          = prod.vtx.pos_y;
            rsp_in.sel_z          = prod.vtx.pos_z;
            rsp_in.sel_w          = prod.vtx.pos_w;
            rsp_in.selected_total = TOTAL_W'(1);
         end else if (best_valid_ff) begin
            rsp_in.has_point      = 1'b1;
            rsp_in.vertex_index   = best_index_ff;
            rsp_in.sel_x          = best_vtx_ff.pos_x;
            rsp_in.sel_y          = best_vtx_ff.pos_y;
            rsp_in.sel_z          = best_vtx_ff.pos_z;
            rsp_in.sel_w          = best_vtx_ff.pos_w;
            rsp_in.selected_total = TOTAL_W'(1);
         end
      end else begin
         if (hit) begin
            rsp_in.has_point    = 1'b1;
            rsp_in.vertex_index = vertex_counter_ff;
            rsp_in.sel_x        = prod.vtx.pos_x;
            rsp_in.sel_y        = prod.vtx.pos_y;
            rsp_in.sel_z        = prod.vtx.pos_z;
            rsp_in.sel_w        = prod.vtx.pos_w;
         end
         rsp_in.selected_total = count_next;
      end
   end

   always_comb begin
      vertex_counter_in = vertex_counter_ff;
      selected_count_in = selected_count_ff;
      best_valid_in     = best_valid_ff;
      if (fire) begin
         if (prod.vtx.mesh_end) begin
            vertex_counter_in = '0;
            selected_count_in = '0;
            best_valid_in     = 1'b0;
         end else begin
            vertex_counter_in = vertex_counter_ff + 1'b1;
            selected_count_in = count_next;
            best_valid_in     = best_valid_ff || nearer;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire && has_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_counter_ff <= '0;
         selected_count_ff <= '0;
         best_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         vertex_counter_ff <= vertex_counter_in;
         selected_count_ff <= selected_count_in;
         best_valid_ff     <= best_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && nearer) begin
         best_dist_ff  <= dist_sq;
         best_index_ff <= vertex_counter_ff;
         best_vtx_ff   <= prod.vtx;
      end
      if (fire && has_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `VPS_ASSERT_NEXT(a_mesh_end_clears, fire && prod.vtx.mesh_end,
                    vertex_counter_ff == '0 && selected_count_ff == '0 && !best_valid_ff,
                    "mesh state not cleared after mesh end")
   `VPS_ASSERT_NEXT(a_count_no_drop, fire && !prod.vtx.mesh_end,
                    selected_count_ff >= $past(selected_count_ff),
                    "selected count fell inside a mesh")
   `VPS_ASSERT_NOW(a_mid_mesh_has_point, rsp_valid_ff && !rsp_ff.final_result,
                   rsp_ff.has_point, "non-final result without a vertex")
   `VPS_ASSERT_NOW(a_best_only_nearest, $rose(best_valid_ff),
                   $past(cfg.select_mode) == SEL_NEAREST,
                   "best candidate taken outside nearest mode")

endmodule

FILE: src/vertex_pick_select_top.sv
// Top level of the vertex pick and select block.
//
// Vertices (signed Q7.8 x, y, z, w) stream in on the req_ channel, one beat
// per clock at full rate while req_stall is low, and are numbered from zero
// within each mesh. The select_mode register picks the rule: all vertices,
// the single vertex nearest the pick point with squared distance strictly
// below the radius, where a zero radius sets no bound (reported only on the
// mesh_end beat), vertices strictly inside four planes, or none. A vertex
// that is selected gives one rsp_ beat at once; a mesh_end vertex always
// gives one closing beat and then returns the per-mesh state to its reset
// value; other vertices give no beat. An accepted req_ beat passes through
// the input register, the product register (squared differences and the
// twelve plane products), then the select stage with its result register.
// The sustained rate is one vertex per cycle while rsp_stall holds no result
// beat, kept by the select stage's running-minimum compare and counters.
// req_stall rises only when all three registers are full and rsp_stall holds
// the result beat. Write configuration only while no vertex is in flight.
module vertex_pick_select_top
   import vps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // vertex channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   // configuration write port
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type  cfg;
   logic     prod_valid;
   prod_type prod;
   logic     prod_take;

   // Hold mode, pick point, radius and the four planes.
   vps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Register the beat, then register its squares and plane products.
   vps_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .prod_valid  (prod_valid),
      .prod        (prod),
      .prod_take   (prod_take)
   );

   // Sum, compare, advance the mesh state and load the result register.
   vps_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .prod_valid  (prod_valid),
      .prod        (prod),
      .prod_take   (prod_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
